// ----- design/assert_macros.svh -----
// Assertion macros shared by the skipper RTL.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at each rising edge out of reset
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked at each rising edge out of reset
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/css_pkg.sv -----
// Shared types and character constants for the comment/string/space skipper.
// No dependencies; used by every module of the block.
package css_pkg;

    localparam int BYTE_POS_WIDTH = 16;
    localparam int STOP_WIDTH     = 17;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_LINE   = 2'd1,
        MODE_BLOCK  = 2'd2,
        MODE_STRING = 2'd3
    } scan_mode_t;

    typedef struct packed {
        logic [7:0]                data_byte;
        logic [7:0]                next_byte;
        logic [BYTE_POS_WIDTH-1:0] byte_position;
        logic                      first_byte;
        logic                      last_byte;
    } scan_item_t;

    typedef struct packed {
        logic [STOP_WIDTH-1:0] stop_position;
        logic                  found;
    } scan_result_t;

    // Control between the input stage and the scan core
    typedef struct packed {
        logic valid;  // input stage holds a byte
        logic take;   // byte leaves the input stage this cycle
    } stage_ctl_t;

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CH_SPACE, CH_LF, CH_CR, CH_TAB};
    endfunction

endpackage

// ----- design/comment_string_space_skipper.sv -----
// Comment, string and whitespace skipper, top level.
// Path: a byte is held in the input register stage, decoded by the scan core and
// its result held in the result register. Throughput: one byte per cycle while the
// result register has room; the mode register loop in the scan core updates once per byte with plain byte compares.
// Reset (rst_n, async low): pipeline empty, normal mode, scan idle until a
// first byte arrives. Depends on css_pkg, css_in_reg, css_scan_core, css_out_reg.
module comment_string_space_skipper #(
    parameter int POSITION_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  next_byte,
    input  logic [15:0] byte_position,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [16:0] stop_position,
    output logic        found
);

    css_pkg::scan_item_t   in_item;
    css_pkg::scan_item_t   stage_item;
    css_pkg::stage_ctl_t   stage_ctl;
    css_pkg::scan_result_t core_result;
    css_pkg::scan_result_t out_result;
    logic                  core_res_valid;
    logic                  out_free;

    // Gather the input fields into one transaction
    assign in_item.data_byte     = data_byte;
    assign in_item.next_byte     = next_byte;
    assign in_item.byte_position = byte_position;
    assign in_item.first_byte    = first_byte;
    assign in_item.last_byte     = last_byte;

    css_in_reg u_in_reg (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_item         (in_item),
        .downstream_free (out_free),
        .ctl             (stage_ctl),
        .item            (stage_item)
    );

    css_scan_core #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_scan_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (stage_ctl),
        .item      (stage_item),
        .res_valid (core_res_valid),
        .result    (core_result)
    );

    css_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (stage_ctl.take && core_res_valid),
        .load_result (core_result),
        .free        (out_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result      (out_result)
    );

    assign stop_position = out_result.stop_position;
    assign found         = out_result.found;

endmodule

// ----- design/css_in_reg.sv -----
// Input register stage: holds one accepted byte transaction for the scan core.
// Depends on css_pkg.
module css_in_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  css_pkg::scan_item_t    in_item,
    input  logic                   downstream_free,
    output css_pkg::stage_ctl_t    ctl,
    output css_pkg::scan_item_t    item
);

    logic                valid_reg;
    logic                valid_next;
    css_pkg::scan_item_t item_reg;
    logic                take;
    logic                load;

    // Advance the held byte whenever the result side has room
    assign take     = valid_reg && downstream_free;
    assign in_ready = !valid_reg || downstream_free;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign ctl.valid = valid_reg;
    assign ctl.take  = take;
    assign item      = item_reg;

endmodule

// ----- design/css_scan_core.sv -----
// Scan core: mode register, previous-byte register and done flag, plus the
// per-byte decode that produces at most one result. Depends on css_pkg and
// assert_macros.svh.
`include "assert_macros.svh"
module css_scan_core #(
    parameter int POSITION_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  css_pkg::stage_ctl_t   ctl,
    input  css_pkg::scan_item_t   item,
    output logic                  res_valid,
    output css_pkg::scan_result_t result
);

    localparam int          EXT_WIDTH = 33;
    localparam logic [EXT_WIDTH-1:0] POS_MASK =
        (EXT_WIDTH'(1) << POSITION_WIDTH) - EXT_WIDTH'(1);
    localparam logic [EXT_WIDTH-1:0] END_MASK =
        (EXT_WIDTH'(1) << (POSITION_WIDTH + 1)) - EXT_WIDTH'(1);

    css_pkg::scan_mode_t mode_reg;
    css_pkg::scan_mode_t mode_next;
    logic [7:0]          prev_reg;
    logic [7:0]          prev_next;
    logic                done_reg;
    logic                done_next;

    css_pkg::scan_mode_t mode_start;
    css_pkg::scan_mode_t mode_after;
    logic                active;
    logic                hit;
    logic                pos_zero;
    logic [EXT_WIDTH-1:0] pos_m;
    logic [EXT_WIDTH-1:0] end_pos;

    // Position masked to the configured width, and the one-past-end value
    assign pos_m    = EXT_WIDTH'(item.byte_position) & POS_MASK;
    assign end_pos  = (pos_m + EXT_WIDTH'(1)) & END_MASK;
    assign pos_zero = (pos_m == '0);

    // A first byte restarts in normal mode; otherwise bytes count only mid-scan
    assign active     = item.first_byte || !done_reg;
    assign mode_start = item.first_byte ? css_pkg::MODE_NORMAL : mode_reg;

    // Decode one byte against the current mode
    always_comb
    begin
        mode_after = mode_start;
        hit        = 1'b0;
        case (mode_start)
            css_pkg::MODE_LINE:
            begin
                if (!pos_zero && item.data_byte == css_pkg::CH_LF)
                begin
                    mode_after = css_pkg::MODE_NORMAL;
                end
            end
            css_pkg::MODE_BLOCK:
            begin
                if (!pos_zero && prev_reg == css_pkg::CH_STAR
                    && item.data_byte == css_pkg::CH_SLASH)
                begin
                    mode_after = css_pkg::MODE_NORMAL;
                end
            end
            css_pkg::MODE_STRING:
            begin
                // escaped quote stays inside the string, except at position zero
                if (item.data_byte == css_pkg::CH_QUOTE
                    && (pos_zero || prev_reg != css_pkg::CH_BSLASH))
                begin
                    mode_after = css_pkg::MODE_NORMAL;
                end
            end
            default:
            begin
                if (item.data_byte == css_pkg::CH_QUOTE)
                begin
                    mode_after = css_pkg::MODE_STRING;
                end
                else if (!item.last_byte && item.data_byte == css_pkg::CH_SLASH
                         && item.next_byte == css_pkg::CH_SLASH)
                begin
                    mode_after = css_pkg::MODE_LINE;
                end
                else if (!item.last_byte && item.data_byte == css_pkg::CH_SLASH
                         && item.next_byte == css_pkg::CH_STAR)
                begin
                    mode_after = css_pkg::MODE_BLOCK;
                end
                else
                begin
                    hit = !css_pkg::is_blank(item.data_byte);
                end
            end
        endcase
    end

    // Next state: update only when a byte leaves the input stage mid-scan
    always_comb
    begin
        mode_next = mode_reg;
        prev_next = prev_reg;
        done_next = done_reg;
        if (ctl.take && active)
        begin
            mode_next = mode_after;
            prev_next = item.data_byte;
            done_next = hit || item.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= css_pkg::MODE_NORMAL;
            prev_reg <= 8'h00;
            done_reg <= 1'b1;
        end
        else
        begin
            mode_reg <= mode_next;
            prev_reg <= prev_next;
            done_reg <= done_next;
        end
    end

    // Outputs: found position, or one past the final byte
    always_comb
    begin
        res_valid = ctl.valid && active && (hit || item.last_byte);
        result.found = hit;
        if (hit)
        begin
            result.stop_position = pos_m[css_pkg::STOP_WIDTH-1:0];
        end
        else
        begin
            result.stop_position = end_pos[css_pkg::STOP_WIDTH-1:0];
        end
    end

    `ASSERT_IMPLY(a_res_needs_byte, res_valid, ctl.valid)
    `ASSERT_NEXT(a_done_after_result, ctl.take && res_valid, done_reg)
    `ASSERT_IMPLY(a_last_ends_scan, ctl.valid && item.last_byte && active, res_valid)
    `ASSERT_NEXT(a_no_state_when_idle, ctl.take && !active, $stable(prev_reg) && done_reg)

endmodule

// ----- design/css_out_reg.sv -----
// Result register: holds one result transaction until the consumer takes it.
// Depends on css_pkg.
module css_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  css_pkg::scan_result_t load_result,
    output logic                  free,
    output logic                  out_valid,
    input  logic                  out_ready,
    output css_pkg::scan_result_t result
);

    logic                  valid_reg;
    logic                  valid_next;
    css_pkg::scan_result_t result_reg;

    // Room for a new result when empty or being drained this cycle
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for comment_string_space_skipper: a predictor tracks the scan
// state per accepted byte, and each result is checked against the oldest prediction.
// Depends on css_pkg and the comment_string_space_skipper RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int RANDOM_ITEMS = 1700;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_TAIL   = 8;
    localparam int CYCLE_LIMIT  = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic [7:0]  next_byte = '0;
    logic [15:0] byte_position = '0;
    logic        first_byte = 1'b0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [16:0] stop_position;
    logic        found;

    // Predictor state
    css_pkg::scan_mode_t mode_now = css_pkg::MODE_NORMAL;
    logic [7:0]          prev_seen_byte = '0;
    bit                  scan_idle = 1'b1;

    css_pkg::scan_result_t expected_stops[$];
    logic [7:0]   scan_text[$];
    int           error_count = 0;
    int           cycle_count = 0;
    int           scored_items = 0;
    bit           calm = 1'b0;
    int           hold_requests = 0;
    int           hold_served = 0;
    int           hold_left = 0;

    comment_string_space_skipper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .next_byte     (next_byte),
        .byte_position (byte_position),
        .first_byte    (first_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .stop_position (stop_position),
        .found         (found)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("comment_string_space_skipper verification failed");
            $finish;
        end
    end

    function automatic bit is_skip_space(input logic [7:0] c);
        return c == css_pkg::CH_SPACE || c == css_pkg::CH_LF || c == css_pkg::CH_CR
            || c == css_pkg::CH_TAB;
    endfunction

    // Advance the scan state by one byte; return 1 when the byte ends the scan
    function automatic bit predict_scan_stop(input logic [7:0] cur, input logic [7:0] nxt,
                                             input logic [15:0] pos, input logic first,
                                             input logic last,
                                             output css_pkg::scan_result_t rec,
                                             output bit ignored);
        bit hit;
        hit = 1'b0;
        ignored = 1'b0;
        rec = '0;
        if (first)
        begin
            mode_now = css_pkg::MODE_NORMAL;
            scan_idle = 1'b0;
        end
        if (scan_idle)
        begin
            ignored = 1'b1;
            return 1'b0;
        end
        case (mode_now)
            css_pkg::MODE_LINE:
                if (pos != 0 && cur == css_pkg::CH_LF)
                    mode_now = css_pkg::MODE_NORMAL;
            css_pkg::MODE_BLOCK:
                if (pos != 0 && prev_seen_byte == css_pkg::CH_STAR
                    && cur == css_pkg::CH_SLASH)
                    mode_now = css_pkg::MODE_NORMAL;
            css_pkg::MODE_STRING:
                // an escaped quote keeps the string open, except at position zero
                if (pos == 0 || prev_seen_byte != css_pkg::CH_BSLASH
                    || cur != css_pkg::CH_QUOTE)
                begin
                    if (cur == css_pkg::CH_QUOTE)
                        mode_now = css_pkg::MODE_NORMAL;
                end
            default:
            begin
                if (!last && cur == css_pkg::CH_SLASH && nxt == css_pkg::CH_STAR)
                    mode_now = css_pkg::MODE_BLOCK;
                if (!last && cur == css_pkg::CH_SLASH && nxt == css_pkg::CH_SLASH)
                    mode_now = css_pkg::MODE_LINE;
                if (cur == css_pkg::CH_QUOTE)
                    mode_now = css_pkg::MODE_STRING;
                if (mode_now == css_pkg::MODE_NORMAL && !is_skip_space(cur))
                    hit = 1'b1;
            end
        endcase
        prev_seen_byte = cur;
        if (hit)
        begin
            rec.stop_position = {1'b0, pos};
            rec.found = 1'b1;
            scan_idle = 1'b1;
            return 1'b1;
        end
        if (last)
        begin
            rec.stop_position = {1'b0, pos} + 17'd1;
            rec.found = 1'b0;
            scan_idle = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Check each result transaction against the oldest prediction
    always @(posedge clk)
    begin
        css_pkg::scan_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_stops.size() == 0)
                report_mismatch($sformatf("unexpected result stop=%0h found=%0b",
                                          stop_position, found));
            else
            begin
                want = expected_stops.pop_front();
                if (stop_position !== want.stop_position)
                    report_mismatch($sformatf("stop_position got %0h want %0h",
                                              stop_position, want.stop_position));
                if (found !== want.found)
                    report_mismatch($sformatf("found got %0b want %0b (stop %0h)",
                                              found, want.found, want.stop_position));
            end
        end
    end

    // Drive result ready: random stalls, requested long holds, calm stretches
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_requests != hold_served)
        begin
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || ($urandom_range(99) >= 13);
    end

    // Offer one byte transaction and record its prediction once accepted
    task automatic send_byte(input logic [7:0] cur, input logic [7:0] nxt,
                             input logic [15:0] pos, input logic first, input logic last);
        css_pkg::scan_result_t rec;
        bit ignored;
        // idle for one cycle now and then
        if (!calm && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= cur;
        next_byte <= nxt;
        byte_position <= pos;
        first_byte <= first;
        last_byte <= last;
        do @(posedge clk); while (!in_ready);
        if (predict_scan_stop(cur, nxt, pos, first, last, rec, ignored))
            expected_stops.push_back(rec);
        if (!ignored)
            scored_items++;
    endtask

    task automatic send_text(input string s, input logic [15:0] start, input bit end_last);
        logic [7:0] nxt;
        for (int i = 0; i < s.len(); i++)
        begin
            nxt = (i + 1 < s.len()) ? s[i+1] : 8'($urandom_range(255));
            send_byte(s[i], nxt, 16'(start + i), i == 0, end_last && i == s.len() - 1);
        end
    endtask

    // Hold input low until every predicted result has arrived
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_stops.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_significant();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (is_skip_space(c) || c == css_pkg::CH_SLASH || c == css_pkg::CH_QUOTE);
        return c;
    endfunction

    function automatic logic [7:0] pick_body_byte();
        case ($urandom_range(5))
            0: return css_pkg::CH_STAR;
            1: return css_pkg::CH_SLASH;
            2: return css_pkg::CH_BSLASH;
            default: return 8'($urandom_range(33, 126));
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3))
            0: return css_pkg::CH_SPACE;
            1: return css_pkg::CH_TAB;
            2: return css_pkg::CH_CR;
            default: return css_pkg::CH_LF;
        endcase
    endfunction

    // Append one construct that the scan passes over
    function automatic void add_skip_token();
        case ($urandom_range(3))
            0: repeat ($urandom_range(1, 3)) scan_text.push_back(pick_blank());
            1:
            begin
                scan_text.push_back(css_pkg::CH_SLASH);
                scan_text.push_back(css_pkg::CH_SLASH);
                repeat ($urandom_range(0, 6)) scan_text.push_back(pick_body_byte());
                scan_text.push_back(css_pkg::CH_LF);
            end
            2:
            begin
                scan_text.push_back(css_pkg::CH_SLASH);
                scan_text.push_back(css_pkg::CH_STAR);
                if ($urandom_range(4) == 0)
                    scan_text.push_back(css_pkg::CH_SLASH);
                else
                begin
                    repeat ($urandom_range(0, 6)) scan_text.push_back(pick_body_byte());
                    scan_text.push_back(css_pkg::CH_STAR);
                    scan_text.push_back(css_pkg::CH_SLASH);
                end
            end
            default:
            begin
                scan_text.push_back(css_pkg::CH_QUOTE);
                repeat ($urandom_range(0, 5))
                begin
                    if ($urandom_range(4) == 0)
                    begin
                        scan_text.push_back(css_pkg::CH_BSLASH);
                        scan_text.push_back(css_pkg::CH_QUOTE);
                    end
                    else
                        scan_text.push_back(pick_body_byte());
                end
                scan_text.push_back(css_pkg::CH_QUOTE);
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_noise_byte();
        case ($urandom_range(9))
            0: return css_pkg::CH_SLASH;
            1: return css_pkg::CH_STAR;
            2: return css_pkg::CH_QUOTE;
            3: return css_pkg::CH_BSLASH;
            4: return pick_blank();
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [15:0] pick_base();
        case ($urandom_range(9))
            0: return 16'hFFFF - 16'($urandom_range(0, 8));
            1: return 16'($urandom_range(16'hFFFF));
            default: return 16'($urandom_range(0, 300));
        endcase
    endfunction

    // Send one well-formed scan; stop most of the time once the scan has ended
    task automatic run_clean_scan();
        logic [15:0] base;
        logic [7:0]  nxt;
        scan_text.delete();
        repeat ($urandom_range(0, 6)) add_skip_token();
        if ($urandom_range(99) < 70 || scan_text.size() == 0)
            scan_text.push_back(pick_significant());
        base = pick_base();
        for (int i = 0; i < scan_text.size(); i++)
        begin
            if (i + 1 < scan_text.size())
                nxt = scan_text[i+1];
            else
                nxt = $urandom_range(1) ? css_pkg::CH_STAR : 8'($urandom_range(255));
            send_byte(scan_text[i], nxt, 16'(base + i), i == 0, i == scan_text.size() - 1);
            if (scan_idle && $urandom_range(3) != 0)
                break;
        end
    endtask

    // Send broken input: random flags, jumping positions, biased bytes
    task automatic run_noise_scan();
        logic [15:0] pos;
        int          len;
        pos = pick_base();
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) < 3)
                pos = 16'($urandom_range(16'hFFFF));
            send_byte(pick_noise_byte(), pick_noise_byte(), pos,
                      (i == 0) ? ($urandom_range(99) < 85) : ($urandom_range(9) == 0),
                      $urandom_range(9) == 0);
            pos = pos + 16'd1;
        end
    endtask

    task automatic test_blank_skip();
        send_text("  \tx", 16'd10, 1'b0);
    endtask

    task automatic test_comment_forms();
        // block comment closed by slash-star-slash
        send_text("\r\n/*/y", 16'd200, 1'b0);
        // line comment does not end at LF on position zero
        send_byte(css_pkg::CH_SLASH, css_pkg::CH_SLASH, 16'd100, 1'b1, 1'b0);
        send_byte(css_pkg::CH_SLASH, css_pkg::CH_LF, 16'd101, 1'b0, 1'b0);
        send_byte(css_pkg::CH_LF, css_pkg::CH_LF, 16'd0, 1'b0, 1'b0);
        send_byte(css_pkg::CH_LF, 8'hFF, 16'd5, 1'b0, 1'b0);
        send_byte(8'hFF, 8'h00, 16'd6, 1'b0, 1'b0);
    endtask

    task automatic test_string_and_end();
        // escaped quote inside the string, then end at the top of the position range
        send_text("\"\\\"\" ", 16'hFFFB, 1'b1);
    endtask

    task automatic test_idle_and_restart();
        send_byte("z", "q", 16'd50, 1'b0, 1'b0);
        send_byte(css_pkg::CH_SPACE, css_pkg::CH_SLASH, 16'd7, 1'b1, 1'b0);
        // slash on the final byte never opens a comment
        send_byte(css_pkg::CH_SLASH, css_pkg::CH_STAR, 16'd8, 1'b1, 1'b1);
        send_byte(8'h00, 8'hFF, 16'd0, 1'b1, 1'b0);
    endtask

    task automatic test_output_backpressure();
        hold_requests <= hold_requests + 1;
        for (int i = 0; i < 40; i++)
            send_byte("k", "k", 16'(1000 + i), 1'b1, 1'b0);
    endtask

    task automatic test_random_scans();
        int start_count;
        int done_count;
        start_count = scored_items;
        while (scored_items < start_count + RANDOM_ITEMS)
        begin
            done_count = scored_items - start_count;
            calm <= (done_count >= 600 && done_count < 900);
            if ($urandom_range(99) < 85)
                run_clean_scan();
            else
                run_noise_scan();
        end
        calm <= 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_blank_skip();
        test_comment_forms();
        wait_drain();
        test_string_and_end();
        wait_drain();
        test_idle_and_restart();
        wait_drain();
        test_output_backpressure();
        wait_drain();
        test_random_scans();
        wait_drain();

        if (error_count == 0 && expected_stops.size() == 0)
            $display("comment_string_space_skipper verification clean");
        else
            $display("comment_string_space_skipper verification failed");
        $finish;
    end

endmodule
